// ===== sv/i2cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cbc_pkg
// Shared types and constants for the I2C bus capture block.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbc_pkg;

   localparam int DATA_BITS = 8;
   localparam int BITCNT_W  = $clog2(DATA_BITS + 1);
   localparam int FIELD_W   = 5;

   typedef enum logic [1:0] {
      FUNC_SCL_RISE = 2'd0,
      FUNC_SDA_EDGE = 2'd1,
      FUNC_READ     = 2'd2,
      FUNC_IDLE     = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      KIND_NOP,
      KIND_SHIFT,
      KIND_SDA_HIGH,
      KIND_SDA_LOW,
      KIND_READ
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic                 sda_bit;
      logic [FIELD_W-1:0]   read_frame;
      logic [FIELD_W-1:0]   read_byte;
      logic                 frame_ok;
      logic                 byte_ok;
   } item_type;

endpackage

`default_nettype wire

// ===== sv/i2cbc_ram.sv =====
// ----------------------------------------------------------------------------
// i2cbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== sv/i2cbc_front.sv =====
// ----------------------------------------------------------------------------
// i2cbc_front
// Accepts request transfers, classifies the bus event and range-checks reads.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbc_front #(
   parameter int FRAMES          = 32,
   parameter int BYTES_PER_FRAME = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [15:0]          req_tdata,
   input  wire logic [1:0]           req_tuser,
   output logic                      item_valid,
   input  wire logic                 item_ready,
   output i2cbc_pkg::item_type       item
);

   logic                 valid_ff;
   i2cbc_pkg::item_type  item_ff;
   i2cbc_pkg::item_type  item_in;
   logic                 scl;

   assign scl = req_tdata[0];

   always_comb begin
      item_in.sda_bit    = req_tdata[1];
      item_in.read_frame = req_tdata[6:2];
      item_in.read_byte  = req_tdata[11:7];
      item_in.frame_ok   = int'(req_tdata[6:2]) < FRAMES;
      item_in.byte_ok    = int'(req_tdata[11:7]) < BYTES_PER_FRAME;
      unique case (i2cbc_pkg::func_type'(req_tuser))
         i2cbc_pkg::FUNC_SCL_RISE: item_in.kind = i2cbc_pkg::KIND_SHIFT;
         i2cbc_pkg::FUNC_SDA_EDGE: begin
            if (!scl) begin
               item_in.kind = i2cbc_pkg::KIND_NOP;
            end else if (req_tdata[1]) begin
               item_in.kind = i2cbc_pkg::KIND_SDA_HIGH;
            end else begin
               item_in.kind = i2cbc_pkg::KIND_SDA_LOW;
            end
         end
         i2cbc_pkg::FUNC_READ:     item_in.kind = i2cbc_pkg::KIND_READ;
         i2cbc_pkg::FUNC_IDLE:     item_in.kind = i2cbc_pkg::KIND_NOP;
         default:                  item_in.kind = i2cbc_pkg::KIND_NOP;
      endcase
   end

   assign req_tready = !valid_ff || item_ready;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         valid_ff <= 1'b1;
      end else if (item_ready) begin
         valid_ff <= 1'b0;
      end
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/i2cbc_queue.sv =====
// ----------------------------------------------------------------------------
// i2cbc_queue
// Two-entry queue of classified items between front and execution.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbc_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire i2cbc_pkg::item_type  in_item,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output i2cbc_pkg::item_type       out_item
);

   i2cbc_pkg::item_type  slot_ff [2];
   logic                 wr_ptr_ff;
   logic                 rd_ptr_ff;
   logic [1:0]           fill_ff;
   logic [1:0]           fill_in;
   logic                 push;
   logic                 pop;

   assign in_ready  = fill_ff != 2'd2;
   assign out_valid = fill_ff != 2'd0;
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      unique case ({push, pop})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

`default_nettype wire

// ===== sv/i2cbc_exec.sv =====
// ----------------------------------------------------------------------------
// i2cbc_exec
// Applies bus events to the capture state, stores bytes and serves readback.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbc_exec #(
   parameter int FRAMES          = 32,
   parameter int BYTES_PER_FRAME = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 item_valid,
   output logic                      item_ready,
   input  wire i2cbc_pkg::item_type  item,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [39:0]               rsp_tdata
);

   localparam int FW = $clog2(FRAMES);
   localparam int BW = $clog2(BYTES_PER_FRAME);
   localparam int CW = $clog2(BYTES_PER_FRAME + 1);
   localparam int AW = $clog2(FRAMES * BYTES_PER_FRAME);
   localparam int DB = i2cbc_pkg::DATA_BITS;
   localparam int BC = i2cbc_pkg::BITCNT_W;

   logic          bus_ff, bus_in;
   logic          pending_ff, pending_in;
   logic [FW-1:0] frame_ff, frame_in;
   logic [BC-1:0] bitcnt_ff, bitcnt_in;
   logic [DB-1:0] shift_ff, shift_in;
   logic [CW-1:0] count_ff, count_in;
   logic          dropped_ff, dropped_in;

   logic          rsp_valid_ff;
   logic          done_ff, done_in;
   logic [DB-1:0] value_ff, value_in;
   logic          acked_ff, acked_in;
   logic          is_read_ff;
   logic          rd_frame_ok_ff;
   logic          rd_byte_ok_ff;
   logic [FW-1:0] rd_frame_ff;
   logic [BW-1:0] rd_byte_ff;

   logic          pop;
   logic          is_read;
   logic          byte_we;
   logic          count_we;
   logic [FW-1:0] rf_idx;
   logic [BW-1:0] rb_idx;
   logic [AW-1:0] byte_waddr;
   logic [AW-1:0] byte_raddr;
   logic [DB:0]   byte_rdata;
   logic [CW-1:0] cnt_rdata;
   logic [CW-1:0] rd_cnt;
   logic          rd_hit;
   logic [DB-1:0] read_value;
   logic          read_acked;

   assign item_ready = !rsp_valid_ff || rsp_tready;
   assign pop        = item_valid && item_ready;
   assign is_read    = item.kind == i2cbc_pkg::KIND_READ;
   assign rf_idx     = FW'(item.read_frame);
   assign rb_idx     = BW'(item.read_byte);
   assign byte_waddr = AW'(frame_ff) * AW'(BYTES_PER_FRAME) + AW'(count_ff);
   assign byte_raddr = AW'(rf_idx) * AW'(BYTES_PER_FRAME) + AW'(rb_idx);

   always_comb begin
      bus_in     = bus_ff;
      pending_in = pending_ff;
      frame_in   = frame_ff;
      bitcnt_in  = bitcnt_ff;
      shift_in   = shift_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      done_in    = 1'b0;
      value_in   = '0;
      acked_in   = 1'b0;
      byte_we    = 1'b0;
      count_we   = 1'b0;
      if (pop) begin
         unique case (item.kind)
            i2cbc_pkg::KIND_SHIFT: begin
               if (bus_ff) begin
                  if (bitcnt_ff < BC'(DB)) begin
                     shift_in  = {shift_ff[DB-2:0], item.sda_bit};
                     bitcnt_in = bitcnt_ff + 1'b1;
                  end else begin
                     bitcnt_in = '0;
                     if (count_ff < CW'(BYTES_PER_FRAME)) begin
                        byte_we  = 1'b1;
                        count_in = count_ff + 1'b1;
                        done_in  = 1'b1;
                        value_in = shift_ff;
                        acked_in = !item.sda_bit;
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
               end
            end
            i2cbc_pkg::KIND_SDA_HIGH: begin
               if (bus_ff) begin
                  bus_in = 1'b0;
               end
            end
            i2cbc_pkg::KIND_SDA_LOW: begin
               if (!bus_ff) begin
                  bus_in = 1'b1;
                  if (pending_ff) begin
                     pending_in = 1'b0;
                  end else if (frame_ff == FW'(FRAMES - 1)) begin
                     frame_in   = '0;
                     bus_in     = 1'b0;
                     pending_in = 1'b1;
                     dropped_in = 1'b0;
                     count_in   = '0;
                     bitcnt_in  = '0;
                  end else begin
                     count_we  = 1'b1;
                     frame_in  = frame_ff + 1'b1;
                     count_in  = '0;
                     bitcnt_in = '0;
                  end
               end
            end
            i2cbc_pkg::KIND_READ: begin
            end
            i2cbc_pkg::KIND_NOP: begin
            end
            default: begin
            end
         endcase
      end
   end

   i2cbc_ram #(
      .WIDTH (DB + 1),
      .DEPTH (FRAMES * BYTES_PER_FRAME)
   ) u_byte_ram (
      .clock   (clock),
      .wr_en   (byte_we),
      .wr_addr (byte_waddr),
      .wr_data ({!item.sda_bit, shift_ff}),
      .rd_en   (pop && is_read && item.frame_ok && item.byte_ok),
      .rd_addr (byte_raddr),
      .rd_data (byte_rdata)
   );

   i2cbc_ram #(
      .WIDTH (CW),
      .DEPTH (FRAMES)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (count_we),
      .wr_addr (frame_ff),
      .wr_data (count_ff),
      .rd_en   (pop && is_read && item.frame_ok),
      .rd_addr (rf_idx),
      .rd_data (cnt_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff       <= 1'b0;
         pending_ff   <= 1'b1;
         frame_ff     <= '0;
         bitcnt_ff    <= '0;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bus_ff     <= bus_in;
         pending_ff <= pending_in;
         frame_ff   <= frame_in;
         bitcnt_ff  <= bitcnt_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      shift_ff <= shift_in;
      if (pop) begin
         done_ff        <= done_in;
         value_ff       <= value_in;
         acked_ff       <= acked_in;
         is_read_ff     <= is_read;
         rd_frame_ok_ff <= item.frame_ok;
         rd_byte_ok_ff  <= item.byte_ok;
         rd_frame_ff    <= rf_idx;
         rd_byte_ff     <= rb_idx;
      end
   end

   always_comb begin
      if (!is_read_ff || !rd_frame_ok_ff) begin
         rd_cnt = '0;
      end else if (rd_frame_ff < frame_ff) begin
         rd_cnt = cnt_rdata;
      end else if (rd_frame_ff == frame_ff) begin
         rd_cnt = count_ff;
      end else begin
         rd_cnt = '0;
      end
   end

   assign rd_hit     = rd_byte_ok_ff && (CW'(rd_byte_ff) < rd_cnt);
   assign read_value = rd_hit ? byte_rdata[DB-1:0] : '0;
   assign read_acked = rd_hit && byte_rdata[DB];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, 6'(rd_cnt), read_acked, read_value, dropped_ff,
                        6'(count_ff), acked_ff, value_ff, done_ff, 5'(frame_ff),
                        bus_ff};

   a_store_room: assert property (@(posedge clock) disable iff (reset)
      byte_we |-> count_ff < CW'(BYTES_PER_FRAME))
      else $error("byte stored into a full frame");

   a_bitcnt_range: assert property (@(posedge clock) disable iff (reset)
      bitcnt_ff <= BC'(DB))
      else $error("bit count past ack clock");

   a_frame_range: assert property (@(posedge clock) disable iff (reset)
      frame_ff <= FW'(FRAMES - 1))
      else $error("frame number out of range");

   a_wrap_clear: assert property (@(posedge clock) disable iff (reset)
      (pop && item.kind == i2cbc_pkg::KIND_SDA_LOW && !bus_ff && !pending_ff
       && frame_ff == FW'(FRAMES - 1))
      |=> (frame_ff == '0 && pending_ff && !bus_ff && count_ff == '0))
      else $error("frame wrap did not clear capture state");

endmodule

`default_nettype wire

// ===== sv/i2c_bus_capture_top.sv =====
// ----------------------------------------------------------------------------
// i2c_bus_capture_top
// Passive I2C bus monitor: start/stop detection, per-frame byte capture and
// readback of stored bytes.
// ----------------------------------------------------------------------------
// The block takes one request transfer per clock while rsp_tready stays high,
// and returns exactly one response transfer per request, in order. A request
// passes the front register, a two-entry queue and the execute stage, which
// loads the response register. The execute cycle, which updates the bus and
// frame state and issues the registered reads of the byte RAM and the
// per-frame count RAM, sets the sustained rate of one item per clock while
// rsp_tready stays high. Frame counts are written when a frame closes, so no
// clearing pass runs after reset.
`default_nettype none

module i2c_bus_capture_top #(
   parameter int FRAMES          = 32,
   parameter int BYTES_PER_FRAME = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [0] scl, [1] sda, [6:2] read_frame, [11:7] read_byte, [15:12] zero
   input  wire logic [15:0] req_tdata,
   // [1:0] func
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] bus_busy, [5:1] frame_now, [6] byte_done, [14:7] byte_value,
   // [15] byte_acked, [21:16] byte_pos, [22] overflow, [30:23] read_value,
   // [31] read_acked, [37:32] read_count, [39:38] zero
   output logic [39:0]      rsp_tdata
);

   logic                 front_valid;
   logic                 front_ready;
   i2cbc_pkg::item_type  front_item;
   logic                 queue_valid;
   logic                 queue_ready;
   i2cbc_pkg::item_type  queue_item;

   i2cbc_front #(
      .FRAMES          (FRAMES),
      .BYTES_PER_FRAME (BYTES_PER_FRAME)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (front_valid),
      .item_ready (front_ready),
      .item       (front_item)
   );

   i2cbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_item  (queue_item)
   );

   i2cbc_exec #(
      .FRAMES          (FRAMES),
      .BYTES_PER_FRAME (BYTES_PER_FRAME)
   ) u_exec (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item_ready (queue_ready),
      .item       (queue_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
